// ===== sv/cfwa_pkg.sv =====
// Shared types and constants for the channel-state frame window averager.
package cfwa_pkg;

  localparam int LANES           = 8;
  localparam int LANE_W          = 3;
  localparam int MAX_FRAME_BYTES = 512;
  localparam int ROWS            = MAX_FRAME_BYTES / LANES;
  localparam int ROW_W           = 6;
  localparam int POS_W           = 10;
  localparam int SUM_W           = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 48;

  localparam logic [47:0] SOURCE_ADDRESS_RESET = 48'h1A00_0000_0001 + 48'd0;
  localparam logic [7:0]  WINDOW_FRAMES_RESET  = 8'd10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FRAMES  = 1'b1;

  typedef struct packed {
    logic [63:0]        csi_word;
    logic [3:0]         word_bytes;
    logic               frame_last;
    logic [47:0]        frame_source;
    logic signed [7:0]  frame_rssi;
    logic [31:0]        frame_sequence;
    logic               sequence_present;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        average_word;
    logic [3:0]         average_bytes;
    logic signed [7:0]  average_rssi;
    logic [31:0]        window_sequence;
    logic               output_last;
  } out_item_t;

endpackage

// ===== sv/csi_frame_window_averager.sv =====
// Top level: windowed per-position averager for channel-state frames.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | in_item  (cfwa_pkg::in_item_t)
//  out     | output    | out_valid/out_ready| out_item (cfwa_pkg::out_item_t)
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Each accepted item does its bank read at accept, and its add and write back
// in the next cycle (one read and one write port per sum bank). An item from
// a foreign source leaves the banks untouched.
// A window close drains ceil(length/8) words (one if empty), each going
// through row read, divider load, 8 divide steps, result register and a
// handshake that stalls on out_ready.
// After reset and after every window close a pass zeroes all 64 rows of the sum
// banks; no item is accepted then. Configuration writes are taken always.
// The input stalls while a result item waits on out_ready.
module csi_frame_window_averager (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  cfwa_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output cfwa_pkg::out_item_t                  out_item,
  input  logic                                 cfg_we,
  input  logic [cfwa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cfwa_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ADD, ST_READ, ST_LOAD, ST_DIV, ST_OUT
  } state_t;

  state_t state;

  logic [47:0]                       source_address;
  logic [7:0]                        window_frames;
  logic signed [cfwa_pkg::SUM_W-1:0] rssi_total;
  logic [7:0]                        frames_in_window;
  logic [cfwa_pkg::POS_W-1:0]        window_length;
  logic [31:0]                       window_seq;
  logic [cfwa_pkg::POS_W-1:0]        byte_position;
  logic [cfwa_pkg::ROW_W-1:0]        clr_row;
  logic                              drain;
  logic [cfwa_pkg::ROW_W:0]          word_idx;
  logic [2:0]                        step;

  logic [cfwa_pkg::LANES-1:0]        add_en;
  logic [cfwa_pkg::ROW_W-1:0]        add_row  [cfwa_pkg::LANES];
  logic [7:0]                        add_byte [cfwa_pkg::LANES];

  // divider lanes: banks 0..7 plus the RSSI lane
  logic [7:0] dv_lo  [cfwa_pkg::LANES+1];
  logic [7:0] dv_rem [cfwa_pkg::LANES+1];
  logic [7:0] dv_q   [cfwa_pkg::LANES+1];
  logic       dv_neg [cfwa_pkg::LANES+1];

  logic                              bank_we    [cfwa_pkg::LANES];
  logic [cfwa_pkg::ROW_W-1:0]        bank_waddr [cfwa_pkg::LANES];
  logic [cfwa_pkg::SUM_W-1:0]        bank_wdata [cfwa_pkg::LANES];
  logic [cfwa_pkg::ROW_W-1:0]        bank_raddr [cfwa_pkg::LANES];
  logic [cfwa_pkg::SUM_W-1:0]        bank_rdata [cfwa_pkg::LANES];

  logic                              in_acc;
  logic                              src_match;
  logic [3:0]                        nb;
  logic [cfwa_pkg::POS_W-1:0]        bp_sum;
  logic [cfwa_pkg::POS_W-1:0]        bp_sat;
  logic [cfwa_pkg::POS_W-1:0]        limit;
  logic [7:0]                        fiw_inc;
  logic                              win_done;
  logic [cfwa_pkg::LANES-1:0]        acc_en;
  logic [cfwa_pkg::ROW_W-1:0]        acc_row  [cfwa_pkg::LANES];
  logic [7:0]                        acc_byte [cfwa_pkg::LANES];
  logic [cfwa_pkg::ROW_W:0]          nwords;
  logic [cfwa_pkg::ROW_W:0]          nwords_eff;
  logic                              word_last;
  logic [cfwa_pkg::POS_W-1:0]        bytes_left;
  logic [3:0]                        word_valid;
  logic [63:0]                       packed_avg;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Work out lane placement of the incoming word across the banks
  always_comb begin
    logic [cfwa_pkg::LANE_W-1:0] li;
    logic [cfwa_pkg::POS_W-1:0]  pos;
    src_match = (in_item.frame_source == source_address);
    nb        = (in_item.word_bytes > 4'(cfwa_pkg::LANES)) ? 4'(cfwa_pkg::LANES)
                                                           : in_item.word_bytes;
    bp_sum    = byte_position + cfwa_pkg::POS_W'(nb);
    bp_sat    = (bp_sum > cfwa_pkg::POS_W'(cfwa_pkg::MAX_FRAME_BYTES))
                ? cfwa_pkg::POS_W'(cfwa_pkg::MAX_FRAME_BYTES) : bp_sum;
    limit     = (frames_in_window == 8'd0)
                ? cfwa_pkg::POS_W'(cfwa_pkg::MAX_FRAME_BYTES) : window_length;
    fiw_inc   = frames_in_window + 8'd1;
    win_done  = (fiw_inc != 8'd0) && (fiw_inc >= window_frames);
    for (int b = 0; b < cfwa_pkg::LANES; b++) begin
      li  = cfwa_pkg::LANE_W'(b) - byte_position[cfwa_pkg::LANE_W-1:0];
      pos = byte_position + cfwa_pkg::POS_W'(li);
      acc_en[b]   = (4'(li) < nb) && (pos < limit) &&
                    (pos < cfwa_pkg::POS_W'(cfwa_pkg::MAX_FRAME_BYTES));
      acc_row[b]  = pos[cfwa_pkg::LANE_W +: cfwa_pkg::ROW_W];
      acc_byte[b] = in_item.csi_word[8*li +: 8];
    end
  end

  // Drive the sum banks: clear sweep, read-modify-write, drain reads
  always_comb begin
    for (int b = 0; b < cfwa_pkg::LANES; b++) begin
      bank_we[b]    = 1'b0;
      bank_waddr[b] = add_row[b];
      bank_wdata[b] = bank_rdata[b] + {{8{add_byte[b][7]}}, add_byte[b]};
      bank_raddr[b] = (state == ST_IDLE) ? acc_row[b]
                                         : word_idx[cfwa_pkg::ROW_W-1:0];
      if (state == ST_CLEAR) begin
        bank_we[b]    = 1'b1;
        bank_waddr[b] = clr_row;
        bank_wdata[b] = '0;
      end else if (state == ST_ADD) begin
        bank_we[b]    = add_en[b];
      end
    end
  end

  for (genvar g = 0; g < cfwa_pkg::LANES; g++) begin : g_bank
    cfwa_ram #(.WIDTH(cfwa_pkg::SUM_W), .DEPTH(cfwa_pkg::ROWS)) u_bank (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (bank_waddr[g]),
      .wdata (bank_wdata[g]),
      .raddr (bank_raddr[g]),
      .rdata (bank_rdata[g])
    );
  end

  // Word bookkeeping for the drain
  always_comb begin
    nwords     = (cfwa_pkg::ROW_W+1)'((window_length + 10'd7) >> cfwa_pkg::LANE_W);
    nwords_eff = (nwords == '0) ? (cfwa_pkg::ROW_W+1)'(1) : nwords;
    word_last  = (word_idx + 1'b1) == nwords_eff;
    bytes_left = window_length - {1'b0, word_idx[cfwa_pkg::ROW_W-1:0], 3'b000};
    word_valid = (bytes_left > 10'd8) ? 4'd8 : bytes_left[3:0];
    for (int b = 0; b < cfwa_pkg::LANES; b++) begin
      packed_avg[8*b +: 8] = (4'(b) < word_valid)
                             ? (dv_neg[b] ? (8'd0 - dv_q[b]) : dv_q[b]) : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      source_address   <= cfwa_pkg::SOURCE_ADDRESS_RESET;
      window_frames    <= cfwa_pkg::WINDOW_FRAMES_RESET;
      rssi_total       <= '0;
      frames_in_window <= '0;
      window_length    <= '0;
      window_seq       <= '0;
      byte_position    <= '0;
      clr_row          <= '0;
      drain            <= 1'b0;
      word_idx         <= '0;
      step             <= '0;
      out_valid        <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          cfwa_pkg::REG_SOURCE_ADDRESS: source_address <= cfg_data;
          cfwa_pkg::REG_WINDOW_FRAMES:  window_frames  <= cfg_data[7:0];
          default: ;
        endcase
      end

      case (state)
        // zero one row of every bank per cycle
        ST_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == cfwa_pkg::ROW_W'(cfwa_pkg::ROWS - 1)) begin
            state <= ST_IDLE;
          end
        end

        // take an item, update frame state, launch bank reads
        ST_IDLE: begin
          if (in_acc) begin
            if (!src_match) begin
              if (in_item.frame_last) begin
                byte_position <= '0;
              end
            end else begin
              add_en <= acc_en;
              for (int b = 0; b < cfwa_pkg::LANES; b++) begin
                add_row[b]  <= acc_row[b];
                add_byte[b] <= acc_byte[b];
              end
              drain <= 1'b0;
              if (in_item.frame_last) begin
                if (frames_in_window == 8'd0) begin
                  window_length <= bp_sat;
                  window_seq    <= in_item.sequence_present ? in_item.frame_sequence
                                                            : 32'd0;
                end
                byte_position    <= '0;
                rssi_total       <= rssi_total + cfwa_pkg::SUM_W'(in_item.frame_rssi);
                frames_in_window <= fiw_inc;
                drain            <= win_done;
              end else begin
                byte_position <= bp_sat;
              end
              state <= ST_ADD;
            end
          end
        end

        // write back sums; start drain on a full window
        ST_ADD: begin
          word_idx <= '0;
          state    <= drain ? ST_READ : ST_IDLE;
        end

        ST_READ: begin
          state <= ST_LOAD;
        end

        // load dividers with magnitudes of this row and the RSSI total
        ST_LOAD: begin
          for (int b = 0; b <= cfwa_pkg::LANES; b++) begin
            logic signed [cfwa_pkg::SUM_W-1:0] s;
            logic [cfwa_pkg::SUM_W-1:0]        a;
            s = (b == cfwa_pkg::LANES) ? rssi_total
                                       : bank_rdata[cfwa_pkg::LANE_W'(b)];
            a = s[cfwa_pkg::SUM_W-1] ? (cfwa_pkg::SUM_W'(0) - s) : s;
            dv_neg[b] <= s[cfwa_pkg::SUM_W-1];
            dv_rem[b] <= a[15:8];
            dv_lo[b]  <= a[7:0];
            dv_q[b]   <= '0;
          end
          step  <= '0;
          state <= ST_DIV;
        end

        // one restoring quotient bit per cycle, eight bits
        ST_DIV: begin
          for (int b = 0; b <= cfwa_pkg::LANES; b++) begin
            logic [8:0] t;
            t = {dv_rem[b], dv_lo[b][7]};
            dv_lo[b] <= {dv_lo[b][6:0], 1'b0};
            if (t >= {1'b0, frames_in_window}) begin
              dv_rem[b] <= 8'(t - {1'b0, frames_in_window});
              dv_q[b]   <= {dv_q[b][6:0], 1'b1};
            end else begin
              dv_rem[b] <= t[7:0];
              dv_q[b]   <= {dv_q[b][6:0], 1'b0};
            end
          end
          step <= step + 1'b1;
          if (step == 3'd7) begin
            state <= ST_OUT;
          end
        end

        // hold the result item until taken
        ST_OUT: begin
          if (!out_valid) begin
            out_valid                <= 1'b1;
            out_item.average_word    <= packed_avg;
            out_item.average_bytes   <= word_valid;
            out_item.average_rssi    <= dv_neg[cfwa_pkg::LANES]
                                        ? (8'd0 - dv_q[cfwa_pkg::LANES])
                                        : dv_q[cfwa_pkg::LANES];
            out_item.window_sequence <= window_seq;
            out_item.output_last     <= word_last;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            if (out_item.output_last) begin
              rssi_total       <= '0;
              frames_in_window <= '0;
              clr_row          <= '0;
              state            <= ST_CLEAR;
            end else begin
              word_idx <= word_idx + 1'b1;
              state    <= ST_READ;
            end
          end
        end

        default: state <= ST_CLEAR;
      endcase
    end
  end

  // Accepted items from the home source are spaced by the write-back cycle
  a_in_spacing: assert property (@(posedge clk) disable iff (rst)
    (in_acc && src_match) |=> !in_ready)
    else $error("item accepted during write-back");

  // Input and output are never open together
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input open while result pending");

  // Last result word leads into the clearing pass
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_item.output_last) |=> (state == ST_CLEAR))
    else $error("window close without clearing pass");

  // Result byte count never exceeds a word
  a_bytes_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.average_bytes <= 4'd8))
    else $error("result byte count out of range");

endmodule

// ===== sv/cfwa_ram.sv =====
// Generic simple dual-port RAM with registered read.
module cfwa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
